>>> rtl/core/nmf_pkg.sv
package nmf_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int CFG_W_BITS = 12;
    localparam int CFG_H_BITS = 16;
    localparam int BANK_DEPTH = MAX_WIDTH / 2;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);
    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = $clog2(Q_DEPTH);
    localparam int Q_CW       = $clog2(Q_DEPTH + 1);
    localparam int EXT_W      = (CFG_W_BITS > COL_W + 1) ? CFG_W_BITS : COL_W + 1;

    // register index, taken from paddr[2]
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [CFG_W_BITS-1:0] WIDTH_RESET  = CFG_W_BITS'(640);
    localparam logic [CFG_H_BITS-1:0] HEIGHT_RESET = CFG_H_BITS'(480);

    typedef logic [7:0]            pix_t;
    typedef pix_t [7:0]            win_t;
    typedef logic [COL_W-1:0]      col_t;
    typedef logic [COL_W:0]        weff_t;
    typedef logic [BANK_AW-1:0]    bidx_t;
    typedef logic [CFG_W_BITS-1:0] wcfg_t;
    typedef logic [CFG_H_BITS-1:0] hcfg_t;

    typedef struct packed {
        logic drain;
        col_t col;
        pix_t pix;
        logic y1;
        logic y2;
        logic x0;
        logic emit_a;
        logic emit_b;
        logic ok_l;
        logic ok_r;
        logic h2;
        logic done;
    } job_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] cnt;
        logic       done;
        win_t       w0;
        win_t       w1;
    } lanes_t;

endpackage

>>> rtl/core/neighbour_median_filter_3x3_unit.sv
// Streaming 3x3 neighbour median: takes one pixel per clock in raster order while
// in_ready is high and returns the average of the 4th and 5th smallest of the eight
// neighbours (center excluded, outside pixels read as zero), one row and one column
// behind the input. A pixel in the last column yields two results, given out in turn;
// a run of frame_width drain items after the frame returns the bottom row, the last
// one flagged with frame_done. Sustained rate is one item per cycle while the output
// slot is free, set by the single write port of the banked line stores and by the
// output slot. Line stores need no clearing after reset. Width and height sit at byte
// addresses 0 and 4; the user writes them only while idle (not enforced by the unit).
module neighbour_median_filter_3x3_unit
    import nmf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [7:0]  pixel_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  median_out,
    output logic        last_of_run,
    output logic        frame_done
);

    wcfg_t  width_reg;
    hcfg_t  height_reg;
    logic   push;
    job_t   push_job;
    logic   q_full;
    logic   q_valid;
    logic   pop;
    job_t   head;
    logic   adv;
    lanes_t lanes;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_HEIGHT) ? 32'(height_reg) : 32'(width_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_WIDTH)
            begin
                width_reg <= pwdata[CFG_W_BITS-1:0];
            end
            else
            begin
                height_reg <= pwdata[CFG_H_BITS-1:0];
            end
        end
    end

    nmf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_width  (width_reg),
        .frame_height (height_reg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .pixel_in     (pixel_in),
        .q_full       (q_full),
        .push         (push),
        .job          (push_job)
    );

    nmf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .head     (head)
    );

    nmf_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .q_valid (q_valid),
        .head    (head),
        .pop     (pop),
        .lanes   (lanes)
    );

    nmf_median u_median (
        .clk         (clk),
        .rst_n       (rst_n),
        .lanes       (lanes),
        .out_ready   (out_ready),
        .adv         (adv),
        .out_valid   (out_valid),
        .median_out  (median_out),
        .last_of_run (last_of_run),
        .frame_done  (frame_done)
    );

    a_no_adv_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !adv)
        else $error("result pipe advanced over a stalled result");

    a_adv_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> adv)
        else $error("result pipe held with an empty output slot");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> last_of_run)
        else $error("frame_done on a result that is not the last of its run");

endmodule

>>> rtl/core/nmf_front.sv
module nmf_front
    import nmf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  wcfg_t frame_width,
    input  hcfg_t frame_height,
    input  logic  in_valid,
    output logic  in_ready,
    input  logic  cmd,
    input  pix_t  pixel_in,
    input  logic  q_full,
    output logic  push,
    output job_t  job
);

    col_t  col_reg, col_next;
    hcfg_t row_reg, row_next;
    col_t  drain_reg, drain_next;

    logic [EXT_W-1:0] fw_ext;
    weff_t w_eff;
    hcfg_t h_eff;
    logic  accept;
    logic  px_ok;
    logic  px_last;
    logic  dr_ok;
    logic  dr_last;
    col_t  d;

    always_comb
    begin
        fw_ext = EXT_W'(frame_width);
        if (fw_ext == '0)
        begin
            w_eff = weff_t'(1);
        end
        else if (fw_ext > EXT_W'(MAX_WIDTH))
        begin
            w_eff = weff_t'(MAX_WIDTH);
        end
        else
        begin
            w_eff = weff_t'(fw_ext);
        end
        h_eff = (frame_height == '0) ? hcfg_t'(1) : frame_height;
    end

    assign px_ok   = row_reg < h_eff;
    assign px_last = ({1'b0, col_reg} + weff_t'(1)) >= w_eff;
    assign dr_ok   = row_reg >= h_eff;
    // clamp the drain column when the width shrank
    assign d       = ({1'b0, drain_reg} >= w_eff) ? col_t'(w_eff - weff_t'(1)) : drain_reg;
    assign dr_last = ({1'b0, d} + weff_t'(1)) >= w_eff;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    assign push     = accept && (cmd ? dr_ok : px_ok);

    always_comb
    begin
        job.drain  = cmd;
        job.col    = cmd ? d : col_reg;
        job.pix    = pixel_in;
        job.y1     = row_reg != '0;
        job.y2     = row_reg > hcfg_t'(1);
        job.x0     = col_reg == '0;
        job.emit_a = (row_reg != '0) && (col_reg != '0);
        job.emit_b = (row_reg != '0) && px_last;
        job.ok_l   = d != '0;
        job.ok_r   = !dr_last;
        job.h2     = h_eff > hcfg_t'(1);
        job.done   = dr_last;
    end

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        drain_next = drain_reg;
        if (push && !cmd)
        begin
            if (px_last)
            begin
                col_next = '0;
                row_next = row_reg + hcfg_t'(1);
            end
            else
            begin
                col_next = col_reg + col_t'(1);
            end
        end
        else if (push && cmd)
        begin
            if (dr_last)
            begin
                drain_next = '0;
                row_next   = '0;
                col_next   = '0;
            end
            else
            begin
                drain_next = d + col_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            drain_reg <= '0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            drain_reg <= drain_next;
        end
    end

endmodule

>>> rtl/core/nmf_queue.sv
module nmf_queue
    import nmf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic q_valid,
    output job_t head
);

    job_t                slot_reg [Q_DEPTH];
    logic [Q_AW-1:0]     wr_ptr_reg;
    logic [Q_AW-1:0]     rd_ptr_reg;
    logic [Q_CW-1:0]     count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign full    = count_reg == Q_CW'(Q_DEPTH);
    assign q_valid = count_reg != '0;
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + Q_CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - Q_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

>>> rtl/core/nmf_back.sv
module nmf_back
    import nmf_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   adv,
    input  logic   q_valid,
    input  job_t   head,
    output logic   pop,
    output lanes_t lanes
);

    // read side: each line store is split into even and odd column banks
    col_t            hd;
    col_t            hd_m;
    weff_t           hd_p;
    bidx_t           idx_c;
    bidx_t           idx_m;
    bidx_t           idx_p;
    bidx_t           addr_a [2];

    pix_t            two_a_reg [2];
    pix_t            two_b_reg [2];
    pix_t            abv_a_reg [2];
    pix_t            abv_b_reg [2];

    logic            e_valid_reg;
    job_t            e_job_reg;
    logic            lw_valid_reg;
    col_t            lw_col_reg;
    pix_t            lw_two_reg;
    pix_t            lw_abv_reg;
    pix_t            wc_reg [6];

    logic            we;
    logic            b0;
    col_t            c;
    col_t            col_l;
    col_t            col_r;
    logic            hit_c;
    logic            hit_l;
    logic            hit_r;
    pix_t            two_cf, two_lf, two_rf;
    pix_t            abv_cf, abv_lf, abv_rf;
    pix_t            top, mid;
    pix_t            wc [6];
    win_t            va, vb, vd;

    assign pop   = adv && q_valid;

    assign hd    = head.col;
    assign hd_m  = hd - col_t'(1);
    assign hd_p  = {1'b0, hd} + weff_t'(1);
    assign idx_c = hd[BANK_AW:1];
    assign idx_m = hd_m[BANK_AW:1];
    assign idx_p = hd_p[BANK_AW:1];

    assign c  = e_job_reg.col;
    assign b0 = c[0];
    assign we = adv && e_valid_reg && !e_job_reg.drain;

    for (genvar b = 0; b < 2; b++)
    begin : g_bank
        pix_t two_mem [BANK_DEPTH];
        pix_t abv_mem [BANK_DEPTH];

        // for drain the center bank reads the center, the other reads both sides
        assign addr_a[b] = (!head.drain || hd[0] == 1'(b)) ? idx_c : idx_m;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                two_a_reg[b] <= two_mem[addr_a[b]];
                abv_a_reg[b] <= abv_mem[addr_a[b]];
                two_b_reg[b] <= two_mem[idx_p];
                abv_b_reg[b] <= abv_mem[idx_p];
            end
            if (we && b0 == 1'(b))
            begin
                two_mem[c[BANK_AW:1]] <= abv_cf;
                abv_mem[c[BANK_AW:1]] <= e_job_reg.pix;
            end
        end
    end

    // forward the write that landed on the edge the reads were taken
    assign col_l = c - col_t'(1);
    assign col_r = c + col_t'(1);
    assign hit_c = lw_valid_reg && (lw_col_reg == c);
    assign hit_l = lw_valid_reg && (lw_col_reg == col_l);
    assign hit_r = lw_valid_reg && (lw_col_reg == col_r);

    assign two_cf = hit_c ? lw_two_reg : two_a_reg[b0];
    assign abv_cf = hit_c ? lw_abv_reg : abv_a_reg[b0];
    assign two_lf = hit_l ? lw_two_reg : two_a_reg[~b0];
    assign abv_lf = hit_l ? lw_abv_reg : abv_a_reg[~b0];
    assign two_rf = hit_r ? lw_two_reg : two_b_reg[~b0];
    assign abv_rf = hit_r ? lw_abv_reg : abv_b_reg[~b0];

    assign top = e_job_reg.y2 ? two_cf : '0;
    assign mid = e_job_reg.y1 ? abv_cf : '0;

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            wc[i] = e_job_reg.x0 ? '0 : wc_reg[i];
        end

        va[0] = wc[0];
        va[1] = wc[1];
        va[2] = wc[2];
        va[3] = wc[3];
        va[4] = wc[5];
        va[5] = top;
        va[6] = mid;
        va[7] = e_job_reg.pix;

        vb[0] = wc[3];
        vb[1] = wc[4];
        vb[2] = wc[5];
        vb[3] = top;
        vb[4] = e_job_reg.pix;
        vb[5] = '0;
        vb[6] = '0;
        vb[7] = '0;

        vd[0] = (e_job_reg.ok_l && e_job_reg.h2) ? two_lf : '0;
        vd[1] = e_job_reg.ok_l ? abv_lf : '0;
        vd[2] = e_job_reg.h2 ? two_cf : '0;
        vd[3] = (e_job_reg.ok_r && e_job_reg.h2) ? two_rf : '0;
        vd[4] = e_job_reg.ok_r ? abv_rf : '0;
        vd[5] = '0;
        vd[6] = '0;
        vd[7] = '0;

        if (e_job_reg.drain)
        begin
            lanes.cnt = 2'd1;
            lanes.w0  = vd;
        end
        else
        begin
            lanes.cnt = {1'b0, e_job_reg.emit_a} + {1'b0, e_job_reg.emit_b};
            lanes.w0  = e_job_reg.emit_a ? va : vb;
        end
        lanes.w1    = vb;
        lanes.valid = e_valid_reg && (lanes.cnt != 2'd0);
        lanes.done  = e_job_reg.drain && e_job_reg.done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg  <= 1'b0;
            lw_valid_reg <= 1'b0;
            for (int i = 0; i < 6; i++)
            begin
                wc_reg[i] <= '0;
            end
        end
        else if (adv)
        begin
            e_valid_reg  <= q_valid;
            lw_valid_reg <= e_valid_reg && !e_job_reg.drain;
            if (e_valid_reg && !e_job_reg.drain)
            begin
                wc_reg[0] <= wc[3];
                wc_reg[1] <= wc[4];
                wc_reg[2] <= wc[5];
                wc_reg[3] <= top;
                wc_reg[4] <= mid;
                wc_reg[5] <= e_job_reg.pix;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_job_reg  <= head;
            lw_col_reg <= c;
            lw_two_reg <= abv_cf;
            lw_abv_reg <= e_job_reg.pix;
        end
    end

endmodule

>>> rtl/core/nmf_median.sv
module nmf_median
    import nmf_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  lanes_t lanes,
    input  logic   out_ready,
    output logic   adv,
    output logic   out_valid,
    output pix_t   median_out,
    output logic   last_of_run,
    output logic   frame_done
);

    lanes_t     s1_reg;
    lanes_t     s2_reg;
    logic [1:0] out_cnt_reg;
    pix_t       out_med0_reg;
    pix_t       out_med1_reg;
    logic       out_done_reg;
    win_t       srt0;
    win_t       srt1;
    pix_t       med0;
    pix_t       med1;

    function automatic logic [15:0] cx(pix_t a, pix_t b);
        return (a > b) ? {a, b} : {b, a};
    endfunction

    function automatic win_t sort_lo(win_t v);
        win_t s;
        s = v;
        {s[2], s[0]} = cx(s[0], s[2]);
        {s[3], s[1]} = cx(s[1], s[3]);
        {s[6], s[4]} = cx(s[4], s[6]);
        {s[7], s[5]} = cx(s[5], s[7]);
        {s[4], s[0]} = cx(s[0], s[4]);
        {s[5], s[1]} = cx(s[1], s[5]);
        {s[6], s[2]} = cx(s[2], s[6]);
        {s[7], s[3]} = cx(s[3], s[7]);
        {s[1], s[0]} = cx(s[0], s[1]);
        {s[3], s[2]} = cx(s[2], s[3]);
        {s[5], s[4]} = cx(s[4], s[5]);
        {s[7], s[6]} = cx(s[6], s[7]);
        return s;
    endfunction

    function automatic win_t sort_hi(win_t v);
        win_t s;
        s = v;
        {s[4], s[2]} = cx(s[2], s[4]);
        {s[5], s[3]} = cx(s[3], s[5]);
        {s[4], s[1]} = cx(s[1], s[4]);
        {s[6], s[3]} = cx(s[3], s[6]);
        {s[2], s[1]} = cx(s[1], s[2]);
        {s[4], s[3]} = cx(s[3], s[4]);
        {s[6], s[5]} = cx(s[5], s[6]);
        return s;
    endfunction

    assign srt0 = sort_hi(s2_reg.w0);
    assign srt1 = sort_hi(s2_reg.w1);
    assign med0 = pix_t'(({1'b0, srt0[3]} + {1'b0, srt0[4]}) >> 1);
    assign med1 = pix_t'(({1'b0, srt1[3]} + {1'b0, srt1[4]}) >> 1);

    // the whole result pipe moves only when the output slot frees up
    assign adv = (out_cnt_reg == 2'd0) || (out_ready && out_cnt_reg == 2'd1);

    assign out_valid   = out_cnt_reg != 2'd0;
    assign median_out  = out_med0_reg;
    assign last_of_run = out_cnt_reg == 2'd1;
    assign frame_done  = out_done_reg && (out_cnt_reg == 2'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg      <= '0;
            s2_reg      <= '0;
            out_cnt_reg <= 2'd0;
        end
        else if (adv)
        begin
            s1_reg       <= lanes;
            s2_reg.valid <= s1_reg.valid;
            s2_reg.cnt   <= s1_reg.cnt;
            s2_reg.done  <= s1_reg.done;
            s2_reg.w0    <= sort_lo(s1_reg.w0);
            s2_reg.w1    <= sort_lo(s1_reg.w1);
            out_cnt_reg  <= s2_reg.valid ? s2_reg.cnt : 2'd0;
        end
        else if (out_ready && out_cnt_reg == 2'd2)
        begin
            out_cnt_reg <= 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_med0_reg <= med0;
            out_med1_reg <= med1;
            out_done_reg <= s2_reg.done;
        end
        else if (out_ready && out_cnt_reg == 2'd2)
        begin
            // advance to the second result of the pair
            out_med0_reg <= out_med1_reg;
        end
    end

endmodule
